/* hw/rtl/pcorr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pearson correlation package
// Widths, codes and control/status bundles shared by the correlation block.
// ----------------------------------------------------------------------------
package pcorr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;

  localparam int CNT_W    = COUNT_BITS + 1;
  localparam int SUM_W    = SAMPLE_BITS + COUNT_BITS + 1;
  localparam int SQ_W     = 2 * SAMPLE_BITS + COUNT_BITS - 1;
  localparam int PROD_W   = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int MAG_W    = 2 * SAMPLE_BITS + 2 * COUNT_BITS;
  localparam int AB_W     = 2 * MAG_W;
  localparam int CORR_W   = 16;
  localparam int ODD_SQ_W = 2 * CORR_W;
  localparam int ACC_W    = AB_W + ODD_SQ_W;
  localparam int MLT_W    = (MAG_W > ODD_SQ_W) ? MAG_W : ODD_SQ_W;

  localparam int TOO_FEW_MAX = 2;
  localparam int Q_ONE       = 1 << (CORR_W - 1);
  localparam int CORR_MAX    = Q_ONE - 1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_FEW  = 2'd1,
    STATUS_ZERO_VAR = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    MUL_NXX,
    MUL_XX,
    MUL_NYY,
    MUL_YY,
    MUL_NXY,
    MUL_XY,
    MUL_AB,
    MUL_CC,
    MUL_ODD,
    MUL_LHS
  } mul_op_e;

  typedef enum logic [4:0] {
    ST_ACCUM,
    ST_DECIDE,
    ST_NXX,
    ST_XX,
    ST_NYY,
    ST_YY,
    ST_NXY,
    ST_XY,
    ST_AB,
    ST_CC,
    ST_CHECK,
    ST_TRY,
    ST_ODD,
    ST_LHS,
    ST_CMP,
    ST_FIN,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic    acc_en;
    logic    acc_clear;
    logic    mul_start;
    logic    mul_commit;
    mul_op_e mul_op;
    logic    set_status;
    status_e status;
    logic    search_init;
    logic    step_adv;
    logic    try_cmp;
    logic    fin;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic overflow;
    logic too_few;
    logic ab_zero;
    logic t_ok;
    logic step_last;
    logic out_free;
  } dp_flags_t;

endpackage
`default_nettype wire

/* hw/rtl/pcorr_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pearson correlation serial multiplier
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pcorr_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pcorr_pkg::MLT_W-1:0]    mlt_i,
  input  logic [pcorr_pkg::ACC_W-1:0]    mcand_i,
  output logic [pcorr_pkg::ACC_W-1:0]    prod_o,
  output logic                           done_o
);

  logic [pcorr_pkg::MLT_W-1:0] mlt_q, mlt_d;
  logic [pcorr_pkg::ACC_W-1:0] mcand_q, mcand_d;
  logic [pcorr_pkg::ACC_W-1:0] prod_q, prod_d;

  always_comb begin
    mlt_d   = mlt_q;
    mcand_d = mcand_q;
    prod_d  = prod_q;
    if (start_i) begin
      mlt_d   = mlt_i;
      mcand_d = mcand_i;
      prod_d  = '0;
    end else if (mlt_q != '0) begin
      if (mlt_q[0]) begin
        prod_d = prod_q + mcand_q;
      end
      mcand_d = mcand_q << 1;
      mlt_d   = mlt_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mlt_q <= '0;
    end else begin
      mlt_q <= mlt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    prod_q  <= prod_d;
  end

  assign prod_o = prod_q;
  assign done_o = (mlt_q == '0);

endmodule
`default_nettype wire

/* hw/rtl/pcorr_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pearson correlation datapath
// Running sums, spread terms, rounding search and the output register.
// ----------------------------------------------------------------------------
module pcorr_dp (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  pcorr_pkg::ctrl_cmd_t                     cmd_i,
  output pcorr_pkg::dp_flags_t                     flags_o,
  input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_x_i,
  input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_y_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [pcorr_pkg::CORR_W-1:0]      correlation_o,
  output logic [1:0]                               status_o,
  output logic [pcorr_pkg::CNT_W-1:0]              pair_count_o
);

  localparam int SB  = pcorr_pkg::SAMPLE_BITS;
  localparam int CW  = pcorr_pkg::CORR_W;
  localparam int MW  = pcorr_pkg::MAG_W;

  logic [pcorr_pkg::CNT_W-1:0]         count_q, count_d;
  logic                                ovf_q, ovf_d;
  logic signed [pcorr_pkg::SUM_W-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic [pcorr_pkg::SQ_W-1:0]          sxx_q, sxx_d, syy_q, syy_d;
  logic signed [pcorr_pkg::PROD_W-1:0] sxy_q, sxy_d;
  logic signed [2*SB-1:0]              xx, yy, xy;

  logic [pcorr_pkg::SUM_W-1:0]  ax, ay;
  logic [pcorr_pkg::PROD_W-1:0] axy;

  logic [pcorr_pkg::MLT_W-1:0] mlt_sel;
  logic [pcorr_pkg::ACC_W-1:0] mcand_sel;
  logic                        mul_neg;
  logic [pcorr_pkg::ACC_W-1:0] prod;
  logic                        mul_done;

  logic signed [MW:0]   term_q;
  logic [MW-1:0]        a_q, b_q, cm_q;
  logic                 cneg_q;
  logic [pcorr_pkg::AB_W-1:0]     ab_q, cc_q;
  logic [pcorr_pkg::ODD_SQ_W-1:0] oddsq_q;
  logic [MW:0]          pz;
  logic signed [MW:0]   sp;
  logic signed [MW+1:0] diff, ndiff;

  logic [CW-1:0] q_q, q_d, step_q, step_d;
  logic [CW:0]   t, tm1;
  logic [CW-1:0] odd;
  logic          lhs_le;
  logic [CW-1:0] q_neg;

  logic [CW-1:0]        corr_q, corr_d;
  pcorr_pkg::status_e   st_q, st_d;

  logic                        out_valid_q, out_valid_d;
  logic [CW-1:0]               out_corr_q;
  logic [1:0]                  out_st_q;
  logic [pcorr_pkg::CNT_W-1:0] out_cnt_q;

  assign xx = sample_x_i * sample_x_i;
  assign yy = sample_y_i * sample_y_i;
  assign xy = sample_x_i * sample_y_i;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    sxx_d   = sxx_q;
    syy_d   = syy_q;
    sxy_d   = sxy_q;
    if (cmd_i.acc_clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
      sx_d    = '0;
      sy_d    = '0;
      sxx_d   = '0;
      syy_d   = '0;
      sxy_d   = '0;
    end else if (cmd_i.acc_en) begin
      if (count_q[pcorr_pkg::CNT_W-1]) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + pcorr_pkg::CNT_W'(1);
        sx_d    = sx_q + pcorr_pkg::SUM_W'(sample_x_i);
        sy_d    = sy_q + pcorr_pkg::SUM_W'(sample_y_i);
        sxx_d   = sxx_q + pcorr_pkg::SQ_W'($unsigned(xx));
        syy_d   = syy_q + pcorr_pkg::SQ_W'($unsigned(yy));
        sxy_d   = sxy_q + pcorr_pkg::PROD_W'(xy);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      sx_q    <= '0;
      sy_q    <= '0;
      sxx_q   <= '0;
      syy_q   <= '0;
      sxy_q   <= '0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      sxx_q   <= sxx_d;
      syy_q   <= syy_d;
      sxy_q   <= sxy_d;
    end
  end

  assign ax  = sx_q[pcorr_pkg::SUM_W-1] ? $unsigned(-sx_q) : $unsigned(sx_q);
  assign ay  = sy_q[pcorr_pkg::SUM_W-1] ? $unsigned(-sy_q) : $unsigned(sy_q);
  assign axy = sxy_q[pcorr_pkg::PROD_W-1] ? $unsigned(-sxy_q) : $unsigned(sxy_q);

  assign t     = {1'b0, q_q} + {1'b0, step_q};
  assign tm1   = t - (CW+1)'(1);
  assign odd   = {tm1[CW-2:0], 1'b1};
  assign q_neg = '0 - q_q;

  always_comb begin
    mlt_sel   = '0;
    mcand_sel = '0;
    mul_neg   = 1'b0;
    unique case (cmd_i.mul_op)
      pcorr_pkg::MUL_NXX: begin
        mlt_sel   = pcorr_pkg::MLT_W'(count_q);
        mcand_sel = pcorr_pkg::ACC_W'(sxx_q);
      end
      pcorr_pkg::MUL_XX: begin
        mlt_sel   = pcorr_pkg::MLT_W'(ax);
        mcand_sel = pcorr_pkg::ACC_W'(ax);
      end
      pcorr_pkg::MUL_NYY: begin
        mlt_sel   = pcorr_pkg::MLT_W'(count_q);
        mcand_sel = pcorr_pkg::ACC_W'(syy_q);
      end
      pcorr_pkg::MUL_YY: begin
        mlt_sel   = pcorr_pkg::MLT_W'(ay);
        mcand_sel = pcorr_pkg::ACC_W'(ay);
      end
      pcorr_pkg::MUL_NXY: begin
        mlt_sel   = pcorr_pkg::MLT_W'(count_q);
        mcand_sel = pcorr_pkg::ACC_W'(axy);
        mul_neg   = sxy_q[pcorr_pkg::PROD_W-1];
      end
      pcorr_pkg::MUL_XY: begin
        mlt_sel   = pcorr_pkg::MLT_W'(ax);
        mcand_sel = pcorr_pkg::ACC_W'(ay);
        mul_neg   = sx_q[pcorr_pkg::SUM_W-1] ^ sy_q[pcorr_pkg::SUM_W-1];
      end
      pcorr_pkg::MUL_AB: begin
        mlt_sel   = pcorr_pkg::MLT_W'(b_q);
        mcand_sel = pcorr_pkg::ACC_W'(a_q);
      end
      pcorr_pkg::MUL_CC: begin
        mlt_sel   = pcorr_pkg::MLT_W'(cm_q);
        mcand_sel = pcorr_pkg::ACC_W'(cm_q);
      end
      pcorr_pkg::MUL_ODD: begin
        mlt_sel   = pcorr_pkg::MLT_W'(odd);
        mcand_sel = pcorr_pkg::ACC_W'(odd);
      end
      pcorr_pkg::MUL_LHS: begin
        mlt_sel   = pcorr_pkg::MLT_W'(oddsq_q);
        mcand_sel = pcorr_pkg::ACC_W'(ab_q);
      end
      default: begin
        mlt_sel   = '0;
        mcand_sel = '0;
      end
    endcase
  end

  pcorr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .mlt_i   (mlt_sel),
    .mcand_i (mcand_sel),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  assign pz    = {1'b0, prod[MW-1:0]};
  assign sp    = mul_neg ? -$signed(pz) : $signed(pz);
  assign diff  = $signed({term_q[MW], term_q}) - $signed({sp[MW], sp});
  assign ndiff = -diff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_commit) begin
      unique case (cmd_i.mul_op)
        pcorr_pkg::MUL_NXX, pcorr_pkg::MUL_NYY, pcorr_pkg::MUL_NXY: begin
          term_q <= sp;
        end
        pcorr_pkg::MUL_XX: begin
          a_q <= diff[MW-1:0];
        end
        pcorr_pkg::MUL_YY: begin
          b_q <= diff[MW-1:0];
        end
        pcorr_pkg::MUL_XY: begin
          cneg_q <= diff[MW+1];
          cm_q   <= diff[MW+1] ? ndiff[MW-1:0] : diff[MW-1:0];
        end
        pcorr_pkg::MUL_AB: begin
          ab_q <= prod[pcorr_pkg::AB_W-1:0];
        end
        pcorr_pkg::MUL_CC: begin
          cc_q <= prod[pcorr_pkg::AB_W-1:0];
        end
        pcorr_pkg::MUL_ODD: begin
          oddsq_q <= prod[pcorr_pkg::ODD_SQ_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The squared numerator is scaled by 2^(2*CORR_W) so that the search finds
  // the magnitude rounded to the nearest Q1.15 step, ties going up.
  assign lhs_le = (prod <= {cc_q, {pcorr_pkg::ODD_SQ_W{1'b0}}});

  always_comb begin
    q_d    = q_q;
    step_d = step_q;
    if (cmd_i.search_init) begin
      q_d    = '0;
      step_d = CW'(pcorr_pkg::Q_ONE);
    end else begin
      if (cmd_i.try_cmp && lhs_le) begin
        q_d = t[CW-1:0];
      end
      if (cmd_i.step_adv) begin
        step_d = step_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q    <= '0;
      step_q <= '0;
    end else begin
      q_q    <= q_d;
      step_q <= step_d;
    end
  end

  always_comb begin
    corr_d = corr_q;
    st_d   = st_q;
    if (cmd_i.set_status) begin
      corr_d = '0;
      st_d   = cmd_i.status;
    end else if (cmd_i.fin) begin
      st_d = pcorr_pkg::STATUS_OK;
      if (cneg_q) begin
        corr_d = q_neg;
      end else if (q_q > CW'(pcorr_pkg::CORR_MAX)) begin
        corr_d = CW'(pcorr_pkg::CORR_MAX);
      end else begin
        corr_d = q_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    corr_q <= corr_d;
    st_q   <= st_d;
  end

  assign out_valid_d = cmd_i.out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_corr_q <= corr_q;
      out_st_q   <= st_q;
      out_cnt_q  <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign correlation_o = $signed(out_corr_q);
  assign status_o      = out_st_q;
  assign pair_count_o  = out_cnt_q;

  assign flags_o.mul_done  = mul_done;
  assign flags_o.overflow  = ovf_q;
  assign flags_o.too_few   = (count_q <= pcorr_pkg::CNT_W'(pcorr_pkg::TOO_FEW_MAX));
  assign flags_o.ab_zero   = (ab_q == '0);
  assign flags_o.t_ok      = (t <= (CW+1)'(pcorr_pkg::Q_ONE));
  assign flags_o.step_last = step_q[0];
  assign flags_o.out_free  = ~out_valid_q | ~out_stall_i;

`ifndef NO_ASSERTIONS
  a_ovf_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> count_q[pcorr_pkg::CNT_W-1])
    else $error("overflow flag set below the count limit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_i.out_load)
    else $error("pending result overwritten");

  a_commit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_commit |-> mul_done)
    else $error("product taken before the multiplier finished");

  a_q_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |-> (q_q <= CW'(pcorr_pkg::Q_ONE)))
    else $error("rounded magnitude above one");
`endif

endmodule
`default_nettype wire

/* hw/rtl/pcorr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pearson correlation controller
// Sequences accumulation, the spread products, the rounding search and output.
// ----------------------------------------------------------------------------
module pcorr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_last_i,
  output logic                  in_stall_o,
  input  pcorr_pkg::dp_flags_t  flags_i,
  output pcorr_pkg::ctrl_cmd_t  cmd_o
);

  pcorr_pkg::state_e state_q, state_d;
  logic              phase_q, phase_d;
  logic              is_mul;
  logic              mul_fin;

  always_comb begin
    unique case (state_q)
      pcorr_pkg::ST_NXX, pcorr_pkg::ST_XX, pcorr_pkg::ST_NYY, pcorr_pkg::ST_YY,
      pcorr_pkg::ST_NXY, pcorr_pkg::ST_XY, pcorr_pkg::ST_AB, pcorr_pkg::ST_CC,
      pcorr_pkg::ST_ODD, pcorr_pkg::ST_LHS: is_mul = 1'b1;
      default:                              is_mul = 1'b0;
    endcase
  end

  assign mul_fin = phase_q & flags_i.mul_done;
  assign phase_d = is_mul & (~phase_q | ~flags_i.mul_done);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcorr_pkg::ST_ACCUM: if (in_valid_i && in_last_i) begin
        state_d = pcorr_pkg::ST_DECIDE;
      end
      pcorr_pkg::ST_DECIDE: begin
        if (flags_i.overflow || flags_i.too_few) begin
          state_d = pcorr_pkg::ST_PUSH;
        end else begin
          state_d = pcorr_pkg::ST_NXX;
        end
      end
      pcorr_pkg::ST_NXX: if (mul_fin) state_d = pcorr_pkg::ST_XX;
      pcorr_pkg::ST_XX:  if (mul_fin) state_d = pcorr_pkg::ST_NYY;
      pcorr_pkg::ST_NYY: if (mul_fin) state_d = pcorr_pkg::ST_YY;
      pcorr_pkg::ST_YY:  if (mul_fin) state_d = pcorr_pkg::ST_NXY;
      pcorr_pkg::ST_NXY: if (mul_fin) state_d = pcorr_pkg::ST_XY;
      pcorr_pkg::ST_XY:  if (mul_fin) state_d = pcorr_pkg::ST_AB;
      pcorr_pkg::ST_AB:  if (mul_fin) state_d = pcorr_pkg::ST_CC;
      pcorr_pkg::ST_CC:  if (mul_fin) state_d = pcorr_pkg::ST_CHECK;
      pcorr_pkg::ST_CHECK: begin
        if (flags_i.ab_zero) begin
          state_d = pcorr_pkg::ST_PUSH;
        end else begin
          state_d = pcorr_pkg::ST_TRY;
        end
      end
      pcorr_pkg::ST_TRY: begin
        if (flags_i.t_ok) begin
          state_d = pcorr_pkg::ST_ODD;
        end else if (flags_i.step_last) begin
          state_d = pcorr_pkg::ST_FIN;
        end
      end
      pcorr_pkg::ST_ODD: if (mul_fin) state_d = pcorr_pkg::ST_LHS;
      pcorr_pkg::ST_LHS: if (mul_fin) state_d = pcorr_pkg::ST_CMP;
      pcorr_pkg::ST_CMP: begin
        if (flags_i.step_last) begin
          state_d = pcorr_pkg::ST_FIN;
        end else begin
          state_d = pcorr_pkg::ST_TRY;
        end
      end
      pcorr_pkg::ST_FIN: state_d = pcorr_pkg::ST_PUSH;
      pcorr_pkg::ST_PUSH: if (flags_i.out_free) begin
        state_d = pcorr_pkg::ST_ACCUM;
      end
      default: state_d = pcorr_pkg::ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      pcorr_pkg::ST_ACCUM: begin
        in_stall_o   = 1'b0;
        cmd_o.acc_en = in_valid_i;
      end
      pcorr_pkg::ST_DECIDE: begin
        if (flags_i.overflow) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = pcorr_pkg::STATUS_OVERFLOW;
        end else if (flags_i.too_few) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = pcorr_pkg::STATUS_TOO_FEW;
        end
      end
      pcorr_pkg::ST_NXX: cmd_o.mul_op = pcorr_pkg::MUL_NXX;
      pcorr_pkg::ST_XX:  cmd_o.mul_op = pcorr_pkg::MUL_XX;
      pcorr_pkg::ST_NYY: cmd_o.mul_op = pcorr_pkg::MUL_NYY;
      pcorr_pkg::ST_YY:  cmd_o.mul_op = pcorr_pkg::MUL_YY;
      pcorr_pkg::ST_NXY: cmd_o.mul_op = pcorr_pkg::MUL_NXY;
      pcorr_pkg::ST_XY:  cmd_o.mul_op = pcorr_pkg::MUL_XY;
      pcorr_pkg::ST_AB:  cmd_o.mul_op = pcorr_pkg::MUL_AB;
      pcorr_pkg::ST_CC:  cmd_o.mul_op = pcorr_pkg::MUL_CC;
      pcorr_pkg::ST_ODD: cmd_o.mul_op = pcorr_pkg::MUL_ODD;
      pcorr_pkg::ST_LHS: cmd_o.mul_op = pcorr_pkg::MUL_LHS;
      pcorr_pkg::ST_CHECK: begin
        if (flags_i.ab_zero) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = pcorr_pkg::STATUS_ZERO_VAR;
        end else begin
          cmd_o.search_init = 1'b1;
        end
      end
      pcorr_pkg::ST_TRY: begin
        cmd_o.step_adv = ~flags_i.t_ok;
      end
      pcorr_pkg::ST_CMP: begin
        cmd_o.try_cmp  = 1'b1;
        cmd_o.step_adv = 1'b1;
      end
      pcorr_pkg::ST_FIN: begin
        cmd_o.fin = 1'b1;
      end
      pcorr_pkg::ST_PUSH: begin
        cmd_o.out_load  = flags_i.out_free;
        cmd_o.acc_clear = flags_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    if (is_mul) begin
      cmd_o.mul_start  = ~phase_q;
      cmd_o.mul_commit = mul_fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcorr_pkg::ST_ACCUM;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pearson_correlation_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pearson correlation top level
// Streaming correlation coefficient of paired signed samples, Q1.15 result.
// ----------------------------------------------------------------------------
// Usage: sample pairs enter on the input channel (in_valid_i / in_stall_o) and
// are summed at one request per cycle. A request with last_i set closes the
// data set; one result then leaves on the output channel (out_valid_o /
// out_stall_i) with the coefficient, a status code and the pair count.
// After a closing request the input is stalled while a shared shift-and-add
// multiplier forms the spread products and a 16-step rounding search runs.
// Each multiply steps through its multiplier operand one bit at a time; early
// exits (count overflow, too few pairs) skip the multiplier. Zero variance is
// found after the eight spread products, before the search starts.
// The result sits in an output register; accumulation of the next data set
// resumes at once, and the next result waits in its output step only if that
// register is still held by a stalling receiver. Reset clears all sums, the
// count, the overflow flag and any pending result.
// ----------------------------------------------------------------------------
module pearson_correlation_top (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_x_i,
  input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_y_i,
  input  logic                                     last_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [pcorr_pkg::CORR_W-1:0]      correlation_o,
  output logic [1:0]                               status_o,
  output logic [pcorr_pkg::CNT_W-1:0]              pair_count_o
);

  pcorr_pkg::ctrl_cmd_t cmd;
  pcorr_pkg::dp_flags_t flags;

  pcorr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (last_i),
    .in_stall_o (in_stall_o),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  pcorr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .flags_o       (flags),
    .sample_x_i    (sample_x_i),
    .sample_y_i    (sample_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .correlation_o (correlation_o),
    .status_o      (status_o),
    .pair_count_o  (pair_count_o)
  );

endmodule
`default_nettype wire

/* tb/sv/pcorr_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pearson correlation result checker
// Watches both channels of the correlation block and keeps its own running
// sums of accepted requests up to the pair limit. On a closing request it
// works out the coefficient with exact wide integer arithmetic and a rounding
// search. It then compares each delivered result field by field, in order.
// ----------------------------------------------------------------------------
module pcorr_result_checker (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  input  logic                                     in_stall_i,
  input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_x_i,
  input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_y_i,
  input  logic                                     last_i,
  input  logic                                     out_valid_i,
  input  logic                                     out_stall_i,
  input  logic signed [pcorr_pkg::CORR_W-1:0]      correlation_i,
  input  logic [1:0]                               status_i,
  input  logic [pcorr_pkg::CNT_W-1:0]              pair_count_i,
  output int                                       mismatch_count_o,
  output int                                       pending_o
);

  localparam logic [pcorr_pkg::CNT_W-1:0] PAIR_LIMIT =
    pcorr_pkg::CNT_W'(1 << pcorr_pkg::COUNT_BITS);

  typedef struct packed {
    logic signed [pcorr_pkg::CORR_W-1:0] corr;
    pcorr_pkg::status_e                  status;
    logic [pcorr_pkg::CNT_W-1:0]         pair_count;
  } corr_result_t;

  corr_result_t                expected_results[$];
  logic [pcorr_pkg::CNT_W-1:0] pair_total;
  longint                      sum_x, sum_y, sum_xx, sum_yy, sum_xy;
  bit                          limit_hit;
  int                          mismatches;

  function automatic void clear_sums();
    pair_total = '0;
    sum_x      = 0;
    sum_y      = 0;
    sum_xx     = 0;
    sum_yy     = 0;
    sum_xy     = 0;
    limit_hit  = 1'b0;
  endfunction

  function automatic logic signed [127:0] spread(longint n, longint s2, longint s1, longint s3);
    logic signed [127:0] w_n, w_s2, w_s1, w_s3;
    w_n  = n;
    w_s2 = s2;
    w_s1 = s1;
    w_s3 = s3;
    return w_n * w_s2 - w_s1 * w_s3;
  endfunction

  function automatic corr_result_t predict_coefficient();
    corr_result_t        res;
    logic signed [127:0] var_x, var_y, cov, var_prod;
    logic [127:0]        cov_mag;
    logic [191:0]        var_wide, cov_sq, lhs;
    int unsigned         q, t, step, odd;
    res.corr       = '0;
    res.pair_count = pair_total;
    if (limit_hit) begin
      res.status = pcorr_pkg::STATUS_OVERFLOW;
    end else if (pair_total <= pcorr_pkg::TOO_FEW_MAX) begin
      res.status = pcorr_pkg::STATUS_TOO_FEW;
    end else begin
      var_x    = spread(longint'(pair_total), sum_xx, sum_x, sum_x);
      var_y    = spread(longint'(pair_total), sum_yy, sum_y, sum_y);
      cov      = spread(longint'(pair_total), sum_xy, sum_x, sum_y);
      var_prod = var_x * var_y;
      if (var_prod == 0) begin
        res.status = pcorr_pkg::STATUS_ZERO_VAR;
      end else begin
        res.status = pcorr_pkg::STATUS_OK;
        var_wide   = {64'd0, var_prod[127:0]};
        cov_mag    = cov[127] ? 128'(-cov) : 128'(cov);
        cov_sq     = {64'd0, cov_mag};
        cov_sq     = (cov_sq * cov_sq) << 32;
        // Largest q with (2q-1)^2 * A*B <= C^2 * 2^32, i.e. round(|r| * 2^15).
        q = 0;
        for (step = pcorr_pkg::Q_ONE; step != 0; step = step >> 1) begin
          t = q + step;
          if (t <= pcorr_pkg::Q_ONE) begin
            odd = 2 * t - 1;
            lhs = 192'(odd) * 192'(odd) * var_wide;
            if (lhs <= cov_sq) begin
              q = t;
            end
          end
        end
        if (cov[127]) begin
          res.corr = pcorr_pkg::CORR_W'(32'h10000 - q);
        end else begin
          res.corr = pcorr_pkg::CORR_W'((q > pcorr_pkg::CORR_MAX) ? pcorr_pkg::CORR_MAX : q);
        end
      end
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
               $signed(want), $signed(got));
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    corr_result_t want;
    if (!rst_ni) begin
      clear_sums();
      expected_results.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, correlation %0d, status %0d, pairs %0d",
                   $time, correlation_i, status_i, pair_count_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("correlation", 32'(want.corr), 32'(correlation_i));
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("pair_count", 32'(want.pair_count), 32'(pair_count_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (pair_total < PAIR_LIMIT) begin
          sum_x      += longint'(sample_x_i);
          sum_y      += longint'(sample_y_i);
          sum_xx     += longint'(sample_x_i) * longint'(sample_x_i);
          sum_yy     += longint'(sample_y_i) * longint'(sample_y_i);
          sum_xy     += longint'(sample_x_i) * longint'(sample_y_i);
          pair_total += 1'b1;
        end else begin
          limit_hit = 1'b1;
        end
        if (last_i) begin
          expected_results.insert(expected_results.size(), predict_coefficient());
          clear_sums();
        end
      end
      pending_o <= expected_results.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

/* tb/sv/pearson_correlation_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pearson correlation testbench
// Drives sample pairs into the correlation block with random gaps and output
// stalls: a directed part, a long receiver hold-off, and random data sets of
// varied shape. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module pearson_correlation_top_tb;

  localparam int MAX_GAP      = 14;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 1300;
  localparam int RANDOM_PAIRS = 2000;

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_SAME,
    SHAPE_MIRROR,
    SHAPE_LINEAR,
    SHAPE_FLAT,
    SHAPE_RAIL
  } set_shape_e;

  logic                                     clk = 1'b0;
  logic                                     rst_n;
  logic                                     in_valid;
  logic                                     in_stall;
  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_x;
  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_y;
  logic                                     last;
  logic                                     out_valid;
  logic                                     out_stall;
  logic signed [pcorr_pkg::CORR_W-1:0]      correlation;
  logic [1:0]                               status;
  logic [pcorr_pkg::CNT_W-1:0]              pair_count;
  int                                       mismatch_count;
  int                                       pending;
  bit                                       gaps_on = 1'b1;
  bit                                       hold_long = 1'b0;
  int                                       random_pairs_sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pearson_correlation_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .sample_x_i    (sample_x),
    .sample_y_i    (sample_y),
    .last_i        (last),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .correlation_o (correlation),
    .status_o      (status),
    .pair_count_o  (pair_count)
  );

  pcorr_result_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .sample_x_i       (sample_x),
    .sample_y_i       (sample_y),
    .last_i           (last),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .correlation_i    (correlation),
    .status_i         (status),
    .pair_count_i     (pair_count),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  task automatic send_pair(input logic signed [pcorr_pkg::SAMPLE_BITS-1:0] x,
                           input logic signed [pcorr_pkg::SAMPLE_BITS-1:0] y,
                           input logic fin);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_x <= x;
    sample_y <= y;
    last     <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_set(input int len, input set_shape_e shape);
    logic signed [pcorr_pkg::SAMPLE_BITS-1:0] x, y, flat;
    flat = pcorr_pkg::SAMPLE_BITS'($urandom);
    for (int i = 0; i < len; i++) begin
      x = pcorr_pkg::SAMPLE_BITS'($urandom);
      y = pcorr_pkg::SAMPLE_BITS'($urandom);
      case (shape)
        SHAPE_SAME: begin
          y = x;
        end
        SHAPE_MIRROR: begin
          y = -x;
        end
        SHAPE_LINEAR: begin
          y = x >>> 1;
          y = y + pcorr_pkg::SAMPLE_BITS'($urandom_range(0, 2047))
                - pcorr_pkg::SAMPLE_BITS'(1024);
        end
        SHAPE_FLAT: begin
          x = flat;
        end
        SHAPE_RAIL: begin
          x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end
        default: begin
        end
      endcase
      send_pair(x, y, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int wait_cycles;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        hold_long   = 1'b0;
        wait_cycles = HOLD_CYCLES;
      end else begin
        wait_cycles = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : stimulus
    int         len;
    int         pick;
    set_shape_e shape;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    sample_x <= '0;
    sample_y <= '0;
    last     <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Too few pairs, at the field extremes.
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);
    // Zero variance in x, then in y.
    send_pair(16'sd5, 16'sd1, 1'b0);
    send_pair(16'sd5, 16'sd2, 1'b0);
    send_pair(16'sd5, 16'sd3, 1'b1);
    send_pair(-16'sd7, 16'sh8000, 1'b0);
    send_pair(16'sd9, 16'sh8000, 1'b0);
    send_pair(16'sd2, 16'sh8000, 1'b1);
    // Perfect positive correlation, saturated to the largest code, then perfect negative.
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);
    send_pair(16'sd1, -16'sd1, 1'b0);
    send_pair(16'sd2, -16'sd2, 1'b0);
    send_pair(16'sd3, -16'sd3, 1'b1);
    // Rail values in every combination.
    send_pair(16'sh8000, 16'sh7fff, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh7fff, 16'sh8000, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);
    wait_drained();

    // Long receiver hold-off while data sets keep coming.
    gaps_on   = 1'b0;
    hold_long = 1'b1;
    for (int i = 0; i < 8; i++) begin
      send_set(4, SHAPE_LINEAR);
    end
    wait_drained();
    gaps_on = 1'b1;

    while (random_pairs_sent < RANDOM_PAIRS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        len = $urandom_range(1, 2);
      end else if (pick == 1) begin
        len = $urandom_range(40, 300);
      end else begin
        len = $urandom_range(3, 24);
      end
      shape   = set_shape_e'($urandom_range(SHAPE_NOISE, SHAPE_RAIL));
      gaps_on = ($urandom_range(0, 3) != 0);
      send_set(len, shape);
      random_pairs_sent += len;
      if ($urandom_range(0, 19) == 0) begin
        wait_drained();
      end
    end

    gaps_on = 1'b1;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #160_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/pcorr_pkg.sv
hw/rtl/pcorr_mul.sv
hw/rtl/pcorr_dp.sv
hw/rtl/pcorr_ctrl.sv
hw/rtl/pearson_correlation_top.sv
tb/sv/pcorr_result_checker.sv
tb/sv/pearson_correlation_top_tb.sv
